/* rtl/polyline_chain_distance_lookup_macros.svh */
// Assertion macros shared by the polyline chain-distance lookup RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef POLYLINE_CHAIN_DISTANCE_LOOKUP_MACROS_SVH
`define POLYLINE_CHAIN_DISTANCE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCDL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

/* rtl/pcdl_pkg.sv */
// Package of the polyline chain-distance lookup: word types, widths, codes,
// controller states and datapath operations. Depends on nothing.
package pcdl_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int COORD_W         = 24;
	localparam int PT_W            = 3 * COORD_W;
	localparam int DIFF_W          = COORD_W + 1;
	localparam int SEG_LEN_W       = 26;
	localparam int MUL_B_W         = SEG_LEN_W + 1;
	localparam int PROD_W          = DIFF_W + MUL_B_W;
	localparam int SQ_W            = 50;
	localparam int LEN_W           = 31;
	localparam int TOL_W           = 52;
	localparam int QD_W            = 32;
	localparam int WRAP_W          = QD_W + 2;
	localparam int DIV_N_W         = 52;
	localparam int DIV_D_W         = LEN_W;
	localparam int DIV_CNT_W       = $clog2(DIV_N_W);
	localparam int SQRT_STEPS      = 25;
	localparam int SQRT_CNT_W      = $clog2(SQRT_STEPS);
	localparam int SQ_STEPS        = 6;
	localparam int SQ_CNT_W        = 3;
	localparam int SEG_W           = 6;
	localparam int CNT_OUT_W       = 7;
	localparam int LOOP_MIN_POINTS = 3;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [QD_W-1:0]    query_distance;
	} pcdl_in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [SEG_W-1:0]          segment_index;
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
		logic signed [COORD_W-1:0] result_z;
		logic [LEN_W-1:0]          chain_length;
		logic [CNT_OUT_W-1:0]      point_count;
		logic                      is_looped;
	} pcdl_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SQ,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_APPEND_WR,
		ST_RANGE_CHK,
		ST_WRAP_WAIT,
		ST_CLASS,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_LERP_A,
		ST_LERP_B,
		ST_LERP_MUL,
		ST_LERP_DIV,
		ST_LERP_WAIT,
		ST_DONE
	} pcdl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_SET_FULL,
		OP_SET_EMPTY,
		OP_APPEND_FIRST,
		OP_SQ_INIT,
		OP_SQ_STEP,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_APPEND_WRITE,
		OP_ONE_POINT,
		OP_RANGE,
		OP_WRAP_START,
		OP_WRAP_FIX,
		OP_TAKE_FIRST,
		OP_TAKE_LAST,
		OP_WALK_INIT,
		OP_WALK_HIT,
		OP_WALK_NEXT,
		OP_LERP_RD_B,
		OP_LERP_CAP_B,
		OP_LERP_MUL,
		OP_LERP_DIV,
		OP_LERP_ACC
	} pcdl_op_t;

	typedef struct packed {
		logic [1:0] act;
		logic       cnt_zero;
		logic       cnt_one;
		logic       full;
		logic       sq_last;
		logic       sqrt_last;
		logic       need_wrap;
		logic       d_zero;
		logic       d_ge_len;
		logic       div_done;
		logic       found;
		logic       walk_end;
		logic       axis_last;
	} pcdl_stat_t;

endpackage

/* rtl/pcdl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pcdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/pcdl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pcdl_pkg for its widths.
module pcdl_div import pcdl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient,
	output logic [DIV_D_W-1:0] remainder
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   nq_q;
	logic [DIV_D_W-1:0]   r_q, d_q;
	logic [DIV_D_W:0]     shifted, diff;
	logic                 ge;
	logic                 last;

	assign shifted = {r_q, nq_q[DIV_N_W-1]};
	assign ge      = shifted >= {1'b0, d_q};
	assign diff    = shifted - {1'b0, d_q};
	assign last    = cnt_q == DIV_CNT_W'(DIV_N_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (busy_q) begin
			nq_q <= {nq_q[DIV_N_W-2:0], ge};
			r_q  <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = nq_q;
	assign remainder = r_q;

endmodule

/* rtl/pcdl_ctrl.sv */
// Controller state machine of the polyline chain-distance lookup.
// Depends on pcdl_pkg and the assertion macro header.
`include "polyline_chain_distance_lookup_macros.svh"

module pcdl_ctrl import pcdl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	output pcdl_op_t   op,
	input  pcdl_stat_t stat
);

	pcdl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (start) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				state_d = ST_DONE;
				if (stat.act == ACT_APPEND && !stat.full && !stat.cnt_zero) begin
					state_d = ST_SQ;
				end else if (stat.act == ACT_QUERY && !stat.cnt_zero && !stat.cnt_one) begin
					state_d = ST_RANGE_CHK;
				end
			end
			ST_SQ:        if (stat.sq_last) state_d = ST_SQRT_LOAD;
			ST_SQRT_LOAD: state_d = ST_SQRT;
			ST_SQRT:      if (stat.sqrt_last) state_d = ST_APPEND_WR;
			ST_APPEND_WR: state_d = ST_DONE;
			ST_RANGE_CHK: state_d = stat.need_wrap ? ST_WRAP_WAIT : ST_CLASS;
			ST_WRAP_WAIT: if (stat.div_done) state_d = ST_CLASS;
			ST_CLASS:     state_d = (stat.d_zero || stat.d_ge_len) ? ST_DONE : ST_WALK_RD;
			ST_WALK_RD:   state_d = ST_WALK_CMP;
			ST_WALK_CMP: begin
				if (stat.found) begin
					state_d = ST_LERP_A;
				end else if (stat.walk_end) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_LERP_A:    state_d = ST_LERP_B;
			ST_LERP_B:    state_d = ST_LERP_MUL;
			ST_LERP_MUL:  state_d = ST_LERP_DIV;
			ST_LERP_DIV:  state_d = ST_LERP_WAIT;
			ST_LERP_WAIT: begin
				if (stat.div_done) begin
					state_d = stat.axis_last ? ST_DONE : ST_LERP_MUL;
				end
			end
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op   = OP_NONE;
		busy = state_q != ST_IDLE;
		done = state_q == ST_DONE;
		case (state_q)
			ST_IDLE:      if (start) op = OP_LATCH;
			ST_DISPATCH: begin
				case (stat.act)
					ACT_CLEAR:  op = OP_CLEAR;
					ACT_APPEND: begin
						if (stat.full) begin
							op = OP_SET_FULL;
						end else if (stat.cnt_zero) begin
							op = OP_APPEND_FIRST;
						end else begin
							op = OP_SQ_INIT;
						end
					end
					ACT_QUERY: begin
						if (stat.cnt_zero) begin
							op = OP_SET_EMPTY;
						end else if (stat.cnt_one) begin
							op = OP_ONE_POINT;
						end else begin
							op = OP_RANGE;
						end
					end
					default:    op = OP_NONE;
				endcase
			end
			ST_SQ:        op = OP_SQ_STEP;
			ST_SQRT_LOAD: op = OP_SQRT_INIT;
			ST_SQRT:      op = OP_SQRT_STEP;
			ST_APPEND_WR: op = OP_APPEND_WRITE;
			ST_RANGE_CHK: op = stat.need_wrap ? OP_WRAP_START : OP_NONE;
			ST_WRAP_WAIT: op = stat.div_done ? OP_WRAP_FIX : OP_NONE;
			ST_CLASS: begin
				if (stat.d_zero) begin
					op = OP_TAKE_FIRST;
				end else if (stat.d_ge_len) begin
					op = OP_TAKE_LAST;
				end else begin
					op = OP_WALK_INIT;
				end
			end
			ST_WALK_CMP: begin
				if (stat.found) begin
					op = OP_WALK_HIT;
				end else if (stat.walk_end) begin
					op = OP_TAKE_LAST;
				end else begin
					op = OP_WALK_NEXT;
				end
			end
			ST_LERP_A:    op = OP_LERP_RD_B;
			ST_LERP_B:    op = OP_LERP_CAP_B;
			ST_LERP_MUL:  op = OP_LERP_MUL;
			ST_LERP_DIV:  op = OP_LERP_DIV;
			ST_LERP_WAIT: op = stat.div_done ? OP_LERP_ACC : OP_NONE;
			default:      op = OP_NONE;
		endcase
	end

	`PCDL_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`PCDL_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	`PCDL_ASSERT_IMPL(a_div_done_waited, clk, arst_n, stat.div_done,
		state_q == ST_WRAP_WAIT || state_q == ST_LERP_WAIT)

endmodule

/* rtl/pcdl_dp.sv */
// Datapath of the polyline chain-distance lookup: point and segment memories,
// shared multiplier, square-root iterator, divider, walk and result registers.
// Depends on pcdl_pkg, pcdl_ram and pcdl_div.
module pcdl_dp import pcdl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int IDX_W = $clog2(MAX_POINTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	input  pcdl_in_t         item,
	input  pcdl_op_t         op,
	output pcdl_stat_t       stat,
	output pcdl_out_t        result
);

	// Architectural state.
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] total_q;
	logic [TOL_W-1:0] tol_q;
	logic [SQ_W-1:0]  ends_sq_q;
	logic signed [COORD_W-1:0] fx_q, fy_q, fz_q, lx_q, ly_q, lz_q;

	// Item and working registers.
	logic [1:0]                act_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [QD_W-1:0]    qd_q;
	logic signed [DIFF_W-1:0]  diff_q [SQ_STEPS];
	logic [SQ_CNT_W-1:0]       sq_cnt_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]           seg_acc_q, ends_acc_q;
	logic [SQ_W-1:0]           v_q, res_q, bit_q;
	logic [SQRT_CNT_W-1:0]     it_cnt_q;
	logic                      need_wrap_q, wrap_neg_q;
	logic [WRAP_W-2:0]         wrap_mag_q;
	logic [LEN_W-1:0]          d_q, walked_q;
	logic [IDX_W-1:0]          idx_q;
	logic [SEG_LEN_W-1:0]      rem_q, len_q;
	logic [PT_W-1:0]           a_q, b_q;
	logic [1:0]                axis_q;

	// Result registers.
	logic [1:0]                status_q;
	logic [SEG_W-1:0]          seg_q;
	logic signed [COORD_W-1:0] rx_q, ry_q, rz_q;

	// Memories.
	logic                 pt_we, sl_we;
	logic [IDX_W-1:0]     pt_waddr, sl_waddr, pt_raddr;
	logic [PT_W-1:0]      pt_rdata;
	logic [SEG_LEN_W-1:0] sl_rdata;

	assign pt_we    = op == OP_APPEND_FIRST || op == OP_APPEND_WRITE;
	assign sl_we    = op == OP_APPEND_WRITE;
	assign pt_waddr = cnt_q[IDX_W-1:0];
	assign sl_waddr = IDX_W'(cnt_q - CNT_W'(1));
	assign pt_raddr = (op == OP_LERP_RD_B) ? idx_q + IDX_W'(1) : idx_q;

	pcdl_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata ({px_q, py_q, pz_q}),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	pcdl_ram #(.WIDTH(SEG_LEN_W), .DEPTH(MAX_POINTS)) u_sl_ram (
		.clk   (clk),
		.we    (sl_we),
		.waddr (sl_waddr),
		.wdata (res_q[SEG_LEN_W-1:0]),
		.raddr (idx_q),
		.rdata (sl_rdata)
	);

	// Divider, shared by the wrap remainder and the interpolation quotient.
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_n, div_q;
	logic [DIV_D_W-1:0] div_d, div_r;
	logic [PROD_W-1:0]  prod_mag;

	assign prod_mag  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign div_start = op == OP_WRAP_START || op == OP_LERP_DIV;
	assign div_n     = (op == OP_WRAP_START) ? DIV_N_W'(wrap_mag_q) : DIV_N_W'(prod_mag);
	assign div_d     = (op == OP_WRAP_START) ? total_q : DIV_D_W'(len_q);

	pcdl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// Shared multiplier.
	logic signed [DIFF_W-1:0]  mul_a, a_c, b_c;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [COORD_W-1:0] a_coord;

	always_comb begin
		case (axis_q)
			2'd0:    a_coord = a_q[PT_W-1 -: COORD_W];
			2'd1:    a_coord = a_q[2*COORD_W-1 -: COORD_W];
			default: a_coord = a_q[COORD_W-1:0];
		endcase
		case (axis_q)
			2'd0:    b_c = DIFF_W'($signed(b_q[PT_W-1 -: COORD_W]));
			2'd1:    b_c = DIFF_W'($signed(b_q[2*COORD_W-1 -: COORD_W]));
			default: b_c = DIFF_W'($signed(b_q[COORD_W-1:0]));
		endcase
		a_c = DIFF_W'(a_coord);
		if (op == OP_LERP_MUL) begin
			mul_a = b_c - a_c;
			mul_b = $signed({1'b0, rem_q});
		end else begin
			case (sq_cnt_q)
				3'd0:    mul_a = diff_q[0];
				3'd1:    mul_a = diff_q[1];
				3'd2:    mul_a = diff_q[2];
				3'd3:    mul_a = diff_q[3];
				3'd4:    mul_a = diff_q[4];
				3'd5:    mul_a = diff_q[5];
				default: mul_a = '0;
			endcase
			mul_b = MUL_B_W'(mul_a);
		end
	end

	// Loop test, range checks and walk compare.
	logic                     looped;
	logic signed [WRAP_W-1:0] qd_ext, len_ext, wrap_v;
	logic                     out_of_range;
	logic [LEN_W-1:0]         rem_walk;
	logic [SQ_W-1:0]          sq_sum;
	logic [LEN_W:0]           total_sum;
	logic [SEG_LEN_W:0]       q_mag;
	logic signed [SEG_LEN_W:0] q_s, lerp_sum;

	assign looped       = cnt_q >= CNT_W'(LOOP_MIN_POINTS) && {2'b0, ends_sq_q} <= tol_q;
	assign qd_ext       = WRAP_W'(qd_q);
	assign len_ext      = $signed({{(WRAP_W - LEN_W){1'b0}}, total_q});
	assign wrap_v       = qd_ext + len_ext;
	assign out_of_range = qd_q[QD_W-1] || qd_ext > len_ext;
	assign rem_walk     = d_q - walked_q;
	assign sq_sum       = res_q + bit_q;
	assign total_sum    = {1'b0, total_q} + (LEN_W + 1)'(res_q[SEG_LEN_W-1:0]);
	assign q_mag        = {1'b0, div_q[SEG_LEN_W-1:0]};
	assign q_s          = prod_q[PROD_W-1] ? -$signed(q_mag) : $signed(q_mag);
	assign lerp_sum     = (SEG_LEN_W + 1)'(a_coord) + q_s;

	// Control-like registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			total_q  <= '0;
			tol_q    <= '0;
			sq_cnt_q <= '0;
			it_cnt_q <= '0;
			axis_q   <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			case (op)
				OP_CLEAR: begin
					cnt_q   <= '0;
					total_q <= '0;
				end
				OP_APPEND_FIRST: cnt_q <= CNT_W'(1);
				OP_SQ_INIT:      sq_cnt_q <= '0;
				OP_SQ_STEP:      sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
				OP_SQRT_INIT:    it_cnt_q <= '0;
				OP_SQRT_STEP:    it_cnt_q <= it_cnt_q + SQRT_CNT_W'(1);
				OP_APPEND_WRITE: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					total_q <= total_sum[LEN_W] ? LEN_MAX : total_sum[LEN_W-1:0];
				end
				OP_WALK_INIT:    idx_q <= '0;
				OP_WALK_NEXT:    idx_q <= idx_q + IDX_W'(1);
				OP_LERP_CAP_B:   axis_q <= '0;
				OP_LERP_ACC:     axis_q <= axis_q + 2'd1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				act_q    <= item.action;
				px_q     <= item.point_x;
				py_q     <= item.point_y;
				pz_q     <= item.point_z;
				qd_q     <= item.query_distance;
				status_q <= STATUS_OK;
				seg_q    <= '0;
				rx_q     <= '0;
				ry_q     <= '0;
				rz_q     <= '0;
			end
			OP_SET_FULL:  status_q <= STATUS_FULL;
			OP_SET_EMPTY: status_q <= STATUS_EMPTY;
			OP_APPEND_FIRST: begin
				fx_q <= px_q;
				fy_q <= py_q;
				fz_q <= pz_q;
				lx_q <= px_q;
				ly_q <= py_q;
				lz_q <= pz_q;
			end
			OP_SQ_INIT: begin
				diff_q[0]  <= DIFF_W'(px_q) - DIFF_W'(lx_q);
				diff_q[1]  <= DIFF_W'(py_q) - DIFF_W'(ly_q);
				diff_q[2]  <= DIFF_W'(pz_q) - DIFF_W'(lz_q);
				diff_q[3]  <= DIFF_W'(px_q) - DIFF_W'(fx_q);
				diff_q[4]  <= DIFF_W'(py_q) - DIFF_W'(fy_q);
				diff_q[5]  <= DIFF_W'(pz_q) - DIFF_W'(fz_q);
				seg_acc_q  <= '0;
				ends_acc_q <= '0;
			end
			OP_SQ_STEP: begin
				prod_q <= mul_a * mul_b;
				if (sq_cnt_q != '0) begin
					if (sq_cnt_q <= SQ_CNT_W'(3)) begin
						seg_acc_q <= seg_acc_q + prod_q[SQ_W-1:0];
					end else begin
						ends_acc_q <= ends_acc_q + prod_q[SQ_W-1:0];
					end
				end
			end
			OP_SQRT_INIT: begin
				v_q   <= seg_acc_q;
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end
			OP_SQRT_STEP: begin
				if (v_q >= sq_sum) begin
					v_q   <= v_q - sq_sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_APPEND_WRITE: begin
				ends_sq_q <= ends_acc_q;
				lx_q      <= px_q;
				ly_q      <= py_q;
				lz_q      <= pz_q;
			end
			OP_ONE_POINT, OP_TAKE_FIRST: begin
				seg_q <= '0;
				rx_q  <= fx_q;
				ry_q  <= fy_q;
				rz_q  <= fz_q;
			end
			OP_TAKE_LAST: begin
				seg_q <= SEG_W'(cnt_q - CNT_W'(2));
				rx_q  <= lx_q;
				ry_q  <= ly_q;
				rz_q  <= lz_q;
			end
			OP_RANGE: begin
				need_wrap_q <= 1'b0;
				wrap_neg_q  <= wrap_v[WRAP_W-1];
				wrap_mag_q  <= wrap_v[WRAP_W-1] ? (WRAP_W - 1)'(-wrap_v)
				                                : (WRAP_W - 1)'(wrap_v);
				if (!out_of_range) begin
					d_q <= qd_q[LEN_W-1:0];
				end else if (looped) begin
					if (total_q == '0) begin
						d_q <= '0;
					end else begin
						need_wrap_q <= 1'b1;
					end
				end else begin
					d_q <= qd_q[QD_W-1] ? '0 : total_q;
				end
			end
			OP_WRAP_FIX: begin
				if (wrap_neg_q && div_r != '0) begin
					d_q <= total_q - div_r;
				end else if (wrap_neg_q) begin
					d_q <= '0;
				end else begin
					d_q <= div_r;
				end
			end
			OP_WALK_INIT: walked_q <= '0;
			OP_WALK_NEXT: walked_q <= walked_q + LEN_W'(sl_rdata);
			OP_WALK_HIT: begin
				seg_q <= SEG_W'(idx_q);
				rem_q <= rem_walk[SEG_LEN_W-1:0];
				len_q <= sl_rdata;
			end
			OP_LERP_RD_B:  a_q <= pt_rdata;
			OP_LERP_CAP_B: b_q <= pt_rdata;
			OP_LERP_MUL:   prod_q <= mul_a * mul_b;
			OP_LERP_ACC: begin
				case (axis_q)
					2'd0:    rx_q <= (len_q == '0) ? a_coord : lerp_sum[COORD_W-1:0];
					2'd1:    ry_q <= (len_q == '0) ? a_coord : lerp_sum[COORD_W-1:0];
					default: rz_q <= (len_q == '0) ? a_coord : lerp_sum[COORD_W-1:0];
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.act       = act_q;
		stat.cnt_zero  = cnt_q == '0;
		stat.cnt_one   = cnt_q == CNT_W'(1);
		stat.full      = cnt_q >= CNT_W'(MAX_POINTS);
		stat.sq_last   = sq_cnt_q == SQ_CNT_W'(SQ_STEPS);
		stat.sqrt_last = it_cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1);
		stat.need_wrap = need_wrap_q;
		stat.d_zero    = d_q == '0;
		stat.d_ge_len  = d_q >= total_q;
		stat.div_done  = div_done;
		stat.found     = rem_walk <= LEN_W'(sl_rdata);
		stat.walk_end  = {1'b0, idx_q} == (IDX_W + 1)'(cnt_q - CNT_W'(2));
		stat.axis_last = axis_q == 2'd2;
	end

	always_comb begin
		result.status        = status_q;
		result.segment_index = seg_q;
		result.result_x      = rx_q;
		result.result_y      = ry_q;
		result.result_z      = rz_q;
		result.chain_length  = total_q;
		result.point_count   = CNT_OUT_W'(cnt_q);
		result.is_looped     = looped;
	end

endmodule

/* rtl/polyline_chain_distance_lookup.sv */
// Top level of the polyline chain-distance lookup.
// Depends on pcdl_pkg, pcdl_ctrl and pcdl_dp.
//
// Usage. A word is offered on item together with start; it is taken at a rising
// edge where start is high and busy is low. The action field selects clear,
// append or query. Exactly one result word follows each taken word: done is high
// for a single cycle and result holds the word during that cycle. The receiver
// cannot hold results off, so the result must be captured in that cycle.
// Sequence: a clear, an unknown action, a full or first append, an empty or
// one-point query go from acceptance straight to done. Any other append runs
// six squarings on the shared multiplier and then the 25-step square-root
// iterator. A query runs the range check and, for a distance inside the chain,
// the segment-memory walk and per axis one division on the 52-step bit-serial
// divider for the interpolation (a wrap adds one more division).
// Items are processed one at a time; busy stays high until the result is out.
// The user must write the loop tolerance register through cfg_we and cfg_wdata
// only while the block is idle; the block does not enforce it. Reset (arst_n
// low) empties the store, zeroes the chain length and the tolerance; the point
// memories hold no reset and are never read before being written.
module polyline_chain_distance_lookup import pcdl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pcdl_in_t         item,
	output logic             done,
	output pcdl_out_t        result,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata
);

	// Command from the controller and status back from the datapath.
	pcdl_op_t   op;
	pcdl_stat_t stat;

	pcdl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.op     (op),
		.stat   (stat)
	);

	pcdl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.op        (op),
		.stat      (stat),
		.result    (result)
	);

endmodule
